/* rtl/core/ort_pkg.sv */
// Package for the ordered record table: record type, codes and state encoding.
package ort_pkg;

  localparam int KEY_W   = 16;
  localparam int NAME_W  = 64;
  localparam int TIME_W  = 32;
  localparam int PARTY_W = 8;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 3;

  // Packed so that the key sits in the lowest bits, matching tdata.
  typedef struct packed {
    logic [PARTY_W-1:0] party_size;
    logic [TIME_W-1:0]  time_code;
    logic [NAME_W-1:0]  name_code;
    logic [KEY_W-1:0]   rec_key;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_SEARCH = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_LIST   = 3'd4
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_KEY   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_SCAN_CHK,
    S_SHIFT,
    S_LIST_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

/* rtl/core/ort_mem.sv */
// Record memory: one write port and one read port with registered read data.
module ort_mem
  import ort_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_data
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/ort_cmp.sv */
// Shared key comparator used by the insert order check and the table scan.
module ort_cmp
  import ort_pkg::*;
(
  input  logic [KEY_W-1:0] a_key,
  input  logic [KEY_W-1:0] b_key,
  output cmp_res_t         res
);

  assign res.eq = (a_key == b_key);
  assign res.gt = (a_key > b_key);

endmodule

/* rtl/core/ordered_record_table.sv */
// Top level of the ordered record table: sequencer, record memory and output register.
//
//   channel | dir | tdata (low bit up)                            | tuser       | tlast
//   in_     | in  | record_key, name_code, time_code, party_size  | action      | -
//   out_    | out | out_key, out_name, out_time, out_party        | status      | last
//
// An item is accepted in the idle state and decoded in the next cycle. Search, update
// and delete then walk the memory one slot per cycle through the single read port;
// insert checks only the last stored record, and list reads one record per result.
// in_tready is high only in the idle state. Reset clears the record count and the control
// state; the memory itself is not cleared. A stalled result holds in the output register
// and the sequencer waits in the emit state before emitting the next one.
module ordered_record_table
  import ort_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // record_key, name_code, time_code, party_size
  input  logic [2:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // out_key, out_name, out_time, out_party
  output logic [2:0]   out_tuser,  // status
  output logic         out_tlast
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [ACT_W-1:0] act_r;
  rec_t            rec_in_r;
  logic [CW-1:0]   used_r, used_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  status_t         res_status_r, res_status_nxt;
  rec_t            res_rec_r, res_rec_nxt;
  logic            res_last_r, res_last_nxt;

  logic            out_valid_r;
  status_t         out_status_r;
  rec_t            out_rec_r;
  logic            out_last_r;

  logic            we;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic [AW-1:0]   rd_addr;
  rec_t            rd_data;
  cmp_res_t        cmp;

  logic            accept;
  logic            slot_free;
  logic            emit_go;
  logic [CW-1:0]   idx_p1;
  logic [CW-1:0]   idx_p2;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_tready;
  assign emit_go   = (state_r == S_EMIT) && slot_free;
  assign idx_p1    = CW'(idx_r) + CW'(1);
  assign idx_p2    = CW'(idx_r) + CW'(2);

  ort_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ort_cmp u_cmp (
    .a_key (rec_in_r.rec_key),
    .b_key (rd_data.rec_key),
    .res   (cmp)
  );

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    res_last_nxt   = res_last_r;
    we             = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    rd_addr        = idx_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_rec_nxt  = '0;
        res_last_nxt = 1'b1;
        idx_nxt      = '0;
        rd_addr      = '0;
        state_nxt    = S_EMIT;
        case (act_r)
          ACT_INSERT: begin
            if (rec_in_r.rec_key == '0) begin
              res_status_nxt = ST_BAD_KEY;
            end else if (used_r == CW'(TABLE_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else if (used_r == '0) begin
              we             = 1'b1;
              wr_addr        = '0;
              wr_data        = rec_in_r;
              used_nxt       = CW'(1);
              res_status_nxt = ST_OK;
              res_rec_nxt    = rec_in_r;
            end else begin
              // Fetch the last stored record for the ascending-key check.
              rd_addr   = AW'(used_r - CW'(1));
              state_nxt = S_INS_CHK;
            end
          end
          ACT_SEARCH, ACT_UPDATE, ACT_DELETE: begin
            if (rec_in_r.rec_key == '0 || used_r == '0) begin
              res_status_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_SCAN_CHK;
            end
          end
          ACT_LIST: begin
            if (used_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_LIST_CHK;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_INS_CHK: begin
        state_nxt = S_EMIT;
        if (cmp.gt) begin
          we             = 1'b1;
          wr_addr        = AW'(used_r);
          wr_data        = rec_in_r;
          used_nxt       = used_r + CW'(1);
          res_status_nxt = ST_OK;
          res_rec_nxt    = rec_in_r;
        end else begin
          res_status_nxt = ST_BAD_KEY;
        end
      end

      S_SCAN_CHK: begin
        // The read port already holds the slot at idx_r; the address for the
        // following slot is issued here so the scan moves one slot per cycle.
        if (cmp.eq) begin
          res_status_nxt = ST_OK;
          res_rec_nxt    = rd_data;
          state_nxt      = S_EMIT;
          case (act_r)
            ACT_UPDATE: begin
              wr_data            = rd_data;
              wr_data.time_code  = rec_in_r.time_code;
              wr_data.party_size = rec_in_r.party_size;
              we                 = 1'b1;
              res_rec_nxt        = wr_data;
            end
            ACT_DELETE: begin
              if (idx_p1 < used_r) begin
                rd_addr   = AW'(idx_p1);
                state_nxt = S_SHIFT;
              end else begin
                used_nxt = used_r - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end else if (idx_p1 == used_r) begin
          res_status_nxt = ST_NOT_FOUND;
          res_rec_nxt    = '0;
          state_nxt      = S_EMIT;
        end else begin
          idx_nxt   = AW'(idx_p1);
          rd_addr   = AW'(idx_p1);
        end
      end

      S_SHIFT: begin
        // The read port holds slot idx_r + 1; move it down one slot.
        we      = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        if (idx_p2 < used_r) begin
          idx_nxt = AW'(idx_p1);
          rd_addr = AW'(idx_p2);
        end else begin
          used_nxt  = used_r - CW'(1);
          state_nxt = S_EMIT;
        end
      end

      S_LIST_CHK: begin
        res_status_nxt = ST_OK;
        res_rec_nxt    = rd_data;
        res_last_nxt   = (idx_p1 == used_r);
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = AW'(idx_p1);
            rd_addr   = AW'(idx_p1);
            state_nxt = S_LIST_CHK;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_tuser;
      rec_in_r <= rec_t'(in_tdata);
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    res_last_r   <= res_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_status_r <= res_status_r;
      out_rec_r    <= res_rec_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rec_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

/* test/ort_reply_checker.sv */
`timescale 1ns / 100ps
// Reply checker for the ordered record table: keeps a shadow table, predicts and compares.
module ort_reply_checker
  import ort_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,   // record_key, name_code, time_code, party_size
  input  logic [2:0]   in_tuser,   // action
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,  // out_key, out_name, out_time, out_party
  input  logic [2:0]   out_tuser,  // status
  input  logic         out_tlast,
  output int           fail_count,
  output int           replies_due
);

  typedef struct packed {
    status_t status;
    rec_t    rec;
    logic    is_last;
  } reply_t;

  rec_t   shadow_rec [TABLE_DEPTH];
  int     shadow_used;
  reply_t due_replies [$];

  initial begin
    fail_count  = 0;
    replies_due = 0;
    shadow_used = 0;
  end

  task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %0s: got 0x%0h, expected 0x%0h", what, got, want);
    fail_count++;
  endtask

  task automatic push_reply(status_t status, rec_t rec, logic is_last);
    reply_t r;
    r.status  = status;
    r.rec     = rec;
    r.is_last = is_last;
    due_replies.push_back(r);
  endtask

  // Key zero is never stored, so it never matches.
  function automatic int slot_of(logic [KEY_W-1:0] key);
    if (key == '0) return -1;
    for (int i = 0; i < shadow_used; i++)
      if (shadow_rec[i].rec_key == key) return i;
    return -1;
  endfunction

  task automatic predict_replies(logic [ACT_W-1:0] code, rec_t req);
    int s;
    s = slot_of(req.rec_key);
    case (code)
      ACT_INSERT: begin
        if (req.rec_key == '0) begin
          push_reply(ST_BAD_KEY, '0, 1'b1);
        end else if (shadow_used >= TABLE_DEPTH) begin
          push_reply(ST_FULL, '0, 1'b1);
        end else if (shadow_used > 0 && shadow_rec[shadow_used-1].rec_key >= req.rec_key) begin
          push_reply(ST_BAD_KEY, '0, 1'b1);
        end else begin
          shadow_rec[shadow_used] = req;
          shadow_used++;
          push_reply(ST_OK, req, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (s < 0) push_reply(ST_NOT_FOUND, '0, 1'b1);
        else push_reply(ST_OK, shadow_rec[s], 1'b1);
      end
      ACT_UPDATE: begin
        if (s < 0) begin
          push_reply(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          shadow_rec[s].time_code  = req.time_code;
          shadow_rec[s].party_size = req.party_size;
          push_reply(ST_OK, shadow_rec[s], 1'b1);
        end
      end
      ACT_DELETE: begin
        if (s < 0) begin
          push_reply(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          push_reply(ST_OK, shadow_rec[s], 1'b1);
          for (int i = s; i + 1 < shadow_used; i++) shadow_rec[i] = shadow_rec[i+1];
          shadow_used--;
        end
      end
      ACT_LIST: begin
        if (shadow_used == 0) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_used; i++)
            push_reply(ST_OK, shadow_rec[i], i == shadow_used - 1);
        end
      end
      default: ;  // unused action codes are dropped without a reply
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    rec_t   got;
    got = out_tdata;
    if (due_replies.size() == 0) begin
      log_mismatch("reply with nothing expected, key", 64'(got.rec_key), '0);
    end else begin
      want = due_replies.pop_front();
      if (out_tuser != want.status)
        log_mismatch("status", 64'(out_tuser), 64'(want.status));
      if (got.rec_key != want.rec.rec_key)
        log_mismatch("key", 64'(got.rec_key), 64'(want.rec.rec_key));
      if (got.name_code != want.rec.name_code)
        log_mismatch("name", got.name_code, want.rec.name_code);
      if (got.time_code != want.rec.time_code)
        log_mismatch("time", 64'(got.time_code), 64'(want.rec.time_code));
      if (got.party_size != want.rec.party_size)
        log_mismatch("party", 64'(got.party_size), 64'(want.rec.party_size));
      if (out_tlast != want.is_last)
        log_mismatch("last", 64'(out_tlast), 64'(want.is_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_used = 0;
      due_replies.delete();
    end else begin
      if (out_tvalid && out_tready) check_reply();
      if (in_tvalid && in_tready) predict_replies(in_tuser, rec_t'(in_tdata));
    end
    replies_due = due_replies.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the ordered record table: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
  import ort_pkg::*;

  localparam int DEPTH         = 32;
  localparam int RANDOM_ITEMS  = 10;
  localparam int PRESSURE_HOLD = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 100;
  localparam logic [ACT_W-1:0] ACT_TOP_CODE = 3'd7;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata   = '0;  // record_key, name_code, time_code, party_size
  logic [2:0]   in_tuser   = '0;  // action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;        // out_key, out_name, out_time, out_party
  logic [2:0]   out_tuser;        // status
  logic         out_tlast;

  int   fail_count;
  int   replies_due;
  logic quiet_mode = 1'b0;
  logic hold_req   = 1'b0;

  // Keys the table should hold, in order; used only to steer the stimulus.
  logic [KEY_W-1:0] live_keys [$];

  ordered_record_table #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ort_reply_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .replies_due (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic rec_t rec_of(logic [KEY_W-1:0] key, logic [NAME_W-1:0] name,
                                  logic [TIME_W-1:0] tcode, logic [PARTY_W-1:0] party);
    rec_t r;
    r.rec_key    = key;
    r.name_code  = name;
    r.time_code  = tcode;
    r.party_size = party;
    return r;
  endfunction

  function automatic rec_t make_rec(logic [KEY_W-1:0] key);
    int pick;
    logic [PARTY_W-1:0] party;
    pick = $urandom_range(0, 7);
    if (pick == 0) party = '0;
    else if (pick == 1) party = '1;
    else party = PARTY_W'($urandom_range(0, 255));
    return rec_of(key, {$urandom, $urandom}, $urandom, party);
  endfunction

  // Mostly a stored key, now and then any key at all.
  function automatic logic [KEY_W-1:0] pick_key();
    if (live_keys.size() > 0 && $urandom_range(0, 4) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return KEY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue(logic [ACT_W-1:0] code, rec_t r);
    int idx;
    int gap;
    int pick;
    idx = -1;
    foreach (live_keys[i]) if (live_keys[i] == r.rec_key) idx = i;
    if (code == ACT_INSERT && r.rec_key != '0 && live_keys.size() < DEPTH &&
        (live_keys.size() == 0 || live_keys[$] < r.rec_key))
      live_keys.push_back(r.rec_key);
    else if (code == ACT_DELETE && idx >= 0)
      live_keys.delete(idx);

    pick = $urandom_range(0, 9);
    if (quiet_mode || pick < 5) gap = 0;
    else if (pick < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= code;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic issue_random();
    int pick;
    int nxt;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      if ($urandom_range(0, 19) == 0) begin
        nxt = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        nxt = $urandom_range(0, 16'hFFFF);
      end else if (live_keys.size() == 0) begin
        nxt = $urandom_range(1, 16'h8000);
      end else begin
        nxt = int'(live_keys[$]) + $urandom_range(1, 1500);
        if (nxt > 16'hFFFF) nxt = 16'hFFFF;
      end
      issue(ACT_INSERT, make_rec(KEY_W'(nxt)));
    end else if (pick < 50) begin
      issue(ACT_SEARCH, make_rec(pick_key()));
    end else if (pick < 65) begin
      issue(ACT_UPDATE, make_rec(pick_key()));
    end else if (pick < 90) begin
      issue(ACT_DELETE, make_rec(pick_key()));
    end else begin
      issue(ACT_LIST, make_rec(pick_key()));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : sink
    int wait_n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        wait_n = PRESSURE_HOLD;
        hold_req = 1'b0;
      end else if (quiet_mode || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        wait_n = $urandom_range(1, 8);
      end else begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 9) < 7) wait_n = $urandom_range(1, 3);
        else if ($urandom_range(0, 2) != 0) wait_n = $urandom_range(4, 12);
        else wait_n = $urandom_range(20, 60);
      end
      repeat (wait_n - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int nxt;
    int idx;
    logic [KEY_W-1:0] gone;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, key extremes, ordering rules, ignored codes, shifts.
    quiet_mode = 1'b1;
    issue(ACT_LIST, rec_of('0, '0, '0, '0));
    issue(ACT_SEARCH, rec_of('0, '1, '1, '1));
    issue(ACT_UPDATE, rec_of(16'h1234, '1, '1, '1));
    issue(ACT_DELETE, rec_of(16'h1234, '0, '0, '0));
    quiet_mode = 1'b0;
    issue(ACT_INSERT, rec_of('0, '1, '1, '1));
    issue(ACT_INSERT, rec_of(16'h0001, '1, '1, '1));
    issue(ACT_INSERT, rec_of(16'h0001, 64'h0123_4567_89AB_CDEF, 32'h1, 8'h2));
    issue(ACT_INSERT, rec_of(16'h8000, '0, '0, '0));
    issue(ACT_INSERT, rec_of(16'h7FFF, '1, '1, '1));
    issue(ACT_INSERT, rec_of(16'hFFFF, 64'hA5A5_5A5A_F0F0_0F0F, 32'h5A5A_A5A5, 8'h80));
    issue(ACT_SEARCH, rec_of(16'h8000, '1, '1, '1));
    issue(ACT_SEARCH, rec_of(16'h0100, '0, '0, '0));
    issue(ACT_UPDATE, rec_of(16'h0001, '1, '0, '0));
    issue(ACT_UPDATE, rec_of(16'hFFFF, '0, '1, '1));
    issue(ACT_LIST, rec_of('0, '0, '0, '0));
    for (int c = int'(ACT_LIST) + 1; c <= int'(ACT_TOP_CODE); c++)
      issue(ACT_W'(c), make_rec(16'h8000));
    issue(ACT_DELETE, rec_of(16'h0001, '0, '0, '0));
    issue(ACT_DELETE, rec_of('0, '0, '0, '0));
    issue(ACT_DELETE, rec_of(16'h4000, '0, '0, '0));
    issue(ACT_LIST, rec_of('0, '0, '0, '0));
    issue(ACT_DELETE, rec_of(16'hFFFF, '0, '0, '0));
    issue(ACT_DELETE, rec_of(16'h8000, '0, '0, '0));
    issue(ACT_LIST, rec_of('0, '0, '0, '0));

    // Fill the table, try past full, list it under a long receiver hold-off, then drain.
    nxt = $urandom_range(1, 1000);
    for (int i = 0; i < DEPTH; i++) begin
      issue(ACT_INSERT, make_rec(KEY_W'(nxt)));
      nxt += $urandom_range(1, 2000);
    end
    issue(ACT_INSERT, make_rec(KEY_W'(nxt)));
    issue(ACT_INSERT, make_rec('0));
    issue(ACT_INSERT, make_rec(16'hFFFF));
    hold_req = 1'b1;
    issue(ACT_LIST, make_rec('0));
    issue(ACT_SEARCH, make_rec(pick_key()));
    issue(ACT_UPDATE, make_rec(pick_key()));
    while (live_keys.size() > 0) begin
      idx  = $urandom_range(0, live_keys.size() - 1);
      gone = live_keys[idx];
      if ($urandom_range(0, 7) == 0) issue(ACT_UPDATE, make_rec(gone));
      issue(ACT_DELETE, make_rec(gone));
      if ($urandom_range(0, 9) == 0) issue(ACT_SEARCH, make_rec(gone));
      if ($urandom_range(0, 15) == 0) issue(ACT_LIST, make_rec('0));
    end

    // Random mix, with one stretch free of idling on both sides.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_mode = (n >= 3 && n < 8);
      if ($urandom_range(0, 24) == 0)
        issue(ACT_W'($urandom_range(int'(ACT_LIST) + 1, int'(ACT_TOP_CODE))), make_rec(pick_key()));
      issue_random();
    end
    quiet_mode = 1'b0;
    in_tvalid <= 1'b0;

    while (replies_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* ordered_record_table.f */
rtl/core/ort_pkg.sv
rtl/core/ort_mem.sv
rtl/core/ort_cmp.sv
rtl/core/ordered_record_table.sv
test/ort_reply_checker.sv
test/tb_top.sv
